// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
// SVM_ASSERT_RST   : checked on every rising clock edge outside reset.
// SVM_ASSERT_ALWAYS: checked on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SVM_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SVM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SVM_ASSERT_RST(label, clk, rst_n, prop, msg)

`define SVM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/svm_pkg.sv =====
`timescale 1ns / 1ps

package svm_pkg;

  localparam int DEF_VOICES       = 16;
  localparam int DEF_SAMPLE_DEPTH = 65536;

  localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PCM_MIN = 16'sh8000;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUEUE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [15:0]         address;
    logic signed [15:0]  sample_in;
    logic [15:0]         sound_length;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  mixed_sample;
    logic [1:0]          status;
    logic [4:0]          active_voices;
  } out_item_t;

  typedef struct packed {
    logic [15:0] address;
    logic [15:0] remaining;
  } voice_entry_t;

endpackage

// ===== src/svm_ram.sv =====
`timescale 1ns / 1ps

module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/svm_sat_add.sv =====
`timescale 1ns / 1ps

module svm_sat_add (
  input  logic signed [15:0] acc_i,
  input  logic signed [15:0] sample_i,
  output logic signed [15:0] sum_o
);

  logic signed [16:0] wide;

  always_comb begin
    wide = 17'(acc_i) + 17'(sample_i);
    // clamp to the 16-bit PCM range
    if (wide > 17'(svm_pkg::PCM_MAX)) begin
      sum_o = svm_pkg::PCM_MAX;
    end else if (wide < 17'(svm_pkg::PCM_MIN)) begin
      sum_o = svm_pkg::PCM_MIN;
    end else begin
      sum_o = wide[15:0];
    end
  end

endmodule

// ===== src/saturating_voice_mixer.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     start / busy              in_item  (svm_pkg::in_item_t)
// result    out_valid (strobe)        out_item (svm_pkg::out_item_t)
//
// One item at a time: busy is high from the edge that takes start until
// the edge that puts the result on out_item, so the next item can be
// taken in the cycle that its predecessor's result is shown.
// Load, clear and a zero-length queue are decoded and answered in S_DISP.
// Queue: the slot scan in S_FIND checks slots from index 0 and claims the
// lowest free slot; a queue that finds the table full scans every slot.
// Tick: S_VRD visits every slot in turn; each active voice costs a
// voice-table read, a sample-memory read and one pass through the adder.
// Reset (rst_n low, synchronous) frees all voices; the sample memory is not
// cleared. The receiver cannot stall: out_valid is high for one cycle only.

`include "assert_macros.svh"

module saturating_voice_mixer #(
  parameter int VOICES       = svm_pkg::DEF_VOICES,
  parameter int SAMPLE_DEPTH = svm_pkg::DEF_SAMPLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  svm_pkg::in_item_t   in_item,
  output logic                out_valid,
  output svm_pkg::out_item_t  out_item
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam logic [31:0] DEPTH_C  = 32'(SAMPLE_DEPTH);
  localparam logic [VW:0] LAST_IDX = (VW + 1)'(VOICES - 1);
  localparam logic [VW:0] END_IDX  = (VW + 1)'(VOICES);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for start
  localparam logic [2:0] S_DISP = 3'd1;  // decode the latched item
  localparam logic [2:0] S_FIND = 3'd2;  // queue: scan for a free slot
  localparam logic [2:0] S_VRD  = 3'd3;  // tick: read voice table entry
  localparam logic [2:0] S_MRD  = 3'd4;  // tick: read sample, update voice
  localparam logic [2:0] S_ACC  = 3'd5;  // tick: add sample into the mix

  // Reduce a 16-bit address modulo SAMPLE_DEPTH by binary compare and
  // subtract; SAMPLE_DEPTH >= 256 keeps the quotient within eight bits.
  function automatic logic [AW-1:0] mem_idx(input logic [15:0] a);
    logic [31:0] r;
    r = {16'd0, a};
    for (int k = 7; k >= 0; k--) begin
      if (r >= (DEPTH_C << k)) begin
        r = r - (DEPTH_C << k);
      end
    end
    return AW'(r);
  endfunction

  logic [2:0]              state_r, state_nxt;
  svm_pkg::in_item_t       item_r, item_nxt;
  logic [VW:0]             idx_r, idx_nxt;
  logic signed [15:0]      acc_r, acc_nxt;
  logic [VOICES-1:0]       active_r, active_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  svm_pkg::out_item_t      out_item_r, out_item_nxt;

  // sample memory port
  logic                    smem_we;
  logic [AW-1:0]           smem_waddr;
  logic [15:0]             smem_wdata;
  logic                    smem_re;
  logic [AW-1:0]           smem_raddr;
  logic [15:0]             smem_rdata;

  // voice table port
  logic                    vtab_we;
  logic [VW-1:0]           vtab_waddr;
  svm_pkg::voice_entry_t   vtab_wdata;
  logic                    vtab_re;
  svm_pkg::voice_entry_t   vtab_rdata;

  logic signed [15:0]      sat_sum;
  logic [VW-1:0]           slot;

  assign slot = idx_r[VW-1:0];

  svm_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_DEPTH)
  ) u_sample_mem (
    .clk   (clk),
    .we    (smem_we),
    .waddr (smem_waddr),
    .wdata (smem_wdata),
    .re    (smem_re),
    .raddr (smem_raddr),
    .rdata (smem_rdata)
  );

  svm_ram #(
    .WIDTH ($bits(svm_pkg::voice_entry_t)),
    .DEPTH (VOICES)
  ) u_voice_tab (
    .clk   (clk),
    .we    (vtab_we),
    .waddr (vtab_waddr),
    .wdata (vtab_wdata),
    .re    (vtab_re),
    .raddr (slot),
    .rdata (vtab_rdata)
  );

  // the one adder that every active voice passes through
  svm_sat_add u_sat_add (
    .acc_i    (acc_r),
    .sample_i ($signed(smem_rdata)),
    .sum_o    (sat_sum)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    smem_we    = 1'b0;
    smem_waddr = mem_idx(item_r.address);
    smem_wdata = item_r.sample_in;
    smem_re    = 1'b0;
    smem_raddr = mem_idx(vtab_rdata.address);
    vtab_we    = 1'b0;
    vtab_waddr = slot;
    vtab_wdata = '{address: item_r.address, remaining: item_r.sound_length};
    vtab_re    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        idx_nxt = '0;
        acc_nxt = '0;
        out_item_nxt.mixed_sample = '0;
        out_item_nxt.status       = svm_pkg::ST_OK;
        unique case (item_r.cmd)
          svm_pkg::CMD_LOAD: begin
            smem_we       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          svm_pkg::CMD_QUEUE: begin
            // zero length is rejected before the slot scan
            if (item_r.sound_length == 16'd0) begin
              out_item_nxt.status = svm_pkg::ST_ZERO_LEN;
              out_valid_nxt       = 1'b1;
              state_nxt           = S_IDLE;
            end else begin
              state_nxt = S_FIND;
            end
          end
          svm_pkg::CMD_TICK: begin
            state_nxt = S_VRD;
          end
          svm_pkg::CMD_CLEAR: begin
            active_nxt    = '0;
            cnt_nxt       = '0;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FIND: begin
        if (!active_r[slot]) begin
          // claim the lowest free slot
          vtab_we          = 1'b1;
          active_nxt[slot] = 1'b1;
          cnt_nxt          = cnt_r + CW'(1);
          out_valid_nxt    = 1'b1;
          state_nxt        = S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          out_item_nxt.status = svm_pkg::ST_FULL;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          idx_nxt = idx_r + (VW + 1)'(1);
        end
      end

      S_VRD: begin
        if (idx_r == END_IDX) begin
          out_item_nxt.mixed_sample = acc_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end else if (active_r[slot]) begin
          vtab_re   = 1'b1;
          state_nxt = S_MRD;
        end else begin
          idx_nxt = idx_r + (VW + 1)'(1);
        end
      end

      S_MRD: begin
        // fetch this voice's sample and advance its pointer and count
        smem_re    = 1'b1;
        vtab_we    = 1'b1;
        vtab_wdata = '{address:   vtab_rdata.address + 16'd1,
                       remaining: vtab_rdata.remaining - 16'd1};
        if (vtab_rdata.remaining == 16'd1) begin
          active_nxt[slot] = 1'b0;
          cnt_nxt          = cnt_r - CW'(1);
        end
        state_nxt = S_ACC;
      end

      S_ACC: begin
        acc_nxt   = sat_sum;
        idx_nxt   = idx_r + (VW + 1)'(1);
        state_nxt = S_VRD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_valid_nxt) begin
      out_item_nxt.active_voices = 5'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // occupancy counter tracks the slot flags
  `SVM_ASSERT_RST(a_cnt_matches, clk, rst_n, cnt_r == $countones(active_r),
    "voice count mismatch")
  // an accepted item makes the block busy
  `SVM_ASSERT_RST(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "item taken, not busy")
  // a result is shown only once the sequencer is back in idle
  `SVM_ASSERT_RST(a_done_idle, clk, rst_n, out_valid_r |-> (state_r == S_IDLE), "result not in idle")
  // only a queue can report an error status
  `SVM_ASSERT_RST(a_status_queue, clk, rst_n,
    (out_valid_r && out_item_r.status != svm_pkg::ST_OK) |-> (item_r.cmd == svm_pkg::CMD_QUEUE),
    "error status outside queue")
  // only a tick can give a nonzero mix
  `SVM_ASSERT_RST(a_mix_tick, clk, rst_n,
    (out_valid_r && out_item_r.mixed_sample != 16'sd0) |-> (item_r.cmd == svm_pkg::CMD_TICK),
    "mix outside tick")

endmodule
